// ===== src/vote_window_command_decider_top_defines.svh =====
`ifndef VOTE_WINDOW_COMMAND_DECIDER_TOP_DEFINES_SVH
`define VOTE_WINDOW_COMMAND_DECIDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VWCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VWCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vwcd_pkg.sv =====
package vwcd_pkg;

	localparam int CLASS_W    = 2;
	localparam int PROB_W     = 17;
	localparam int TIME_W     = 32;
	localparam int CMD_W      = 2;
	localparam int SWCNT_W    = 16;
	localparam int WIN_W      = 5;
	localparam int VMIN_W     = 5;
	localparam int REFR_W     = 16;
	localparam int CFG_DATA_W = 17;
	localparam int REG_IDX_W  = 3;

	localparam logic [CMD_W-1:0] CMD_CLOSE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OPEN      = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNCERTAIN = 2'd3;

	localparam logic FUNC_FORGET = 1'b1;

	localparam logic [WIN_W-1:0]  WIN_RST  = 5'd8;
	localparam logic [VMIN_W-1:0] VMIN_RST = 5'd5;
	localparam logic [PROB_W-1:0] PROB_RST = 17'd45875;
	localparam logic [REFR_W-1:0] REFR_RST = 16'd300;
	localparam logic [CMD_W-1:0]  CMD_RST  = 2'd0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_LENGTH   = 3'd0,
		REG_VOTES_MIN       = 3'd1,
		REG_PROB_MIN        = 3'd2,
		REG_REFRACTORY_MS   = 3'd3,
		REG_INITIAL_COMMAND = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             we;
		logic             clr;
		logic [CMD_W-1:0] vote;
	} cell_ctrl_t;

endpackage

// ===== src/vwcd_in_if.sv =====
interface vwcd_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [vwcd_pkg::CLASS_W-1:0] class_in;
	logic [vwcd_pkg::PROB_W-1:0]  prob;
	logic [vwcd_pkg::TIME_W-1:0]  now_ms;

	modport source(output valid, func, class_in, prob, now_ms, input ready);
	modport sink(input valid, func, class_in, prob, now_ms, output ready);
endinterface

// ===== src/vwcd_out_if.sv =====
interface vwcd_out_if;
	logic                        valid;
	logic                        ready;
	logic                        switched;
	logic [vwcd_pkg::CMD_W-1:0]   command;
	logic [vwcd_pkg::SWCNT_W-1:0] switch_count;

	modport source(output valid, switched, command, switch_count, input ready);
	modport sink(input valid, switched, command, switch_count, output ready);
endinterface

// ===== src/vwcd_cell.sv =====
module vwcd_cell #(
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vwcd_pkg::cell_ctrl_t ctrl,
	input  logic                 sel,
	input  logic                 en,
	input  logic [CNT_W-1:0]     close_in,
	input  logic [CNT_W-1:0]     open_in,
	output logic [CNT_W-1:0]     close_out,
	output logic [CNT_W-1:0]     open_out
);

	logic [vwcd_pkg::CMD_W-1:0] vote_q;
	logic [CNT_W-1:0]           close_s1;
	logic [CNT_W-1:0]           open_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vote_q   <= vwcd_pkg::CMD_UNCERTAIN;
			close_s1 <= '0;
			open_s1  <= '0;
		end else begin
			if (ctrl.clr) begin
				vote_q <= vwcd_pkg::CMD_UNCERTAIN;
			end else if (ctrl.we && sel) begin
				vote_q <= ctrl.vote;
			end
			close_s1 <= close_in + CNT_W'(en && (vote_q == vwcd_pkg::CMD_CLOSE));
			open_s1  <= open_in + CNT_W'(en && (vote_q == vwcd_pkg::CMD_OPEN));
		end
	end

	assign close_out = close_s1;
	assign open_out  = open_s1;

endmodule

// ===== src/vote_window_command_decider_top.sv =====
// Vote window command decider.
// Channel vote carries one transaction per classifier decision (func 0) or
// history forget request (func 1); channel result returns exactly one
// transaction per input: switched flag, current command, switch count.
// Configuration is written through cfg_we / cfg_idx / cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// The vote history lives in a row of HISTORY_DEPTH cells; close and open
// counts ripple down the row one cell per cycle.
// A decision passes through the count state while its counts ripple down
// the cell row, then through the result state; a forget request goes
// straight to the result state. Vote takes a new transaction only when
// idle, once the result of the last one has left the result state.
// Result sits in an output register; vote is ready again while a result
// still waits, and a stalled receiver holds the next result in the final
// step until the register frees.
// Reset clears all history cells to uncertain, the command to rest and the
// switch count to zero, and loads the configuration reset values.
`include "vote_window_command_decider_top_defines.svh"

module vote_window_command_decider_top #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	vwcd_in_if.sink                            vote,
	vwcd_out_if.source                         result,
	input  logic                               cfg_we,
	input  logic [vwcd_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [vwcd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SW = (CW > vwcd_pkg::WIN_W) ? CW : vwcd_pkg::WIN_W;
	localparam int MW = (CW > vwcd_pkg::VMIN_W) ? CW : vwcd_pkg::VMIN_W;
	localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_RESULT
	} state_t;

	state_t                          state_q;
	logic [vwcd_pkg::WIN_W-1:0]      win_len_q;
	logic [vwcd_pkg::VMIN_W-1:0]     vmin_q;
	logic [vwcd_pkg::PROB_W-1:0]     prob_min_q;
	logic [vwcd_pkg::REFR_W-1:0]     refr_q;
	logic [vwcd_pkg::CMD_W-1:0]      cmd_q;
	logic                            has_sw_q;
	logic [vwcd_pkg::TIME_W-1:0]     last_q;
	logic [vwcd_pkg::SWCNT_W-1:0]    sw_total_q;
	logic [CW-1:0]                   wi_q;
	logic [CW-1:0]                   fill_q;
	logic [CW-1:0]                   cnt_q;
	logic                            full_q;
	logic                            is_vote_q;
	logic [vwcd_pkg::TIME_W-1:0]     now_q;
	logic                            out_valid_q;
	logic                            sw_out_q;
	logic [vwcd_pkg::CMD_W-1:0]      cmd_out_q;
	logic [vwcd_pkg::SWCNT_W-1:0]    cnt_out_q;

	logic [SW-1:0]                   win_len_s;
	logic [SW-1:0]                   win_s;
	logic [CW-1:0]                   win;
	logic                            accept;
	logic                            accept_vote;
	logic [CW-1:0]                   fill_next;
	vwcd_pkg::cell_ctrl_t            cell_ctrl;
	logic [CW-1:0]                   close_c [HISTORY_DEPTH+1];
	logic [CW-1:0]                   open_c  [HISTORY_DEPTH+1];
	logic [MW-1:0]                   closes_m;
	logic [MW-1:0]                   opens_m;
	logic [MW-1:0]                   vmin_m;
	logic                            tgt_close;
	logic                            tgt_open;
	logic [vwcd_pkg::CMD_W-1:0]      dec_target;
	logic [vwcd_pkg::TIME_W-1:0]     elapsed;
	logic                            refr_block;
	logic                            dec_sw;
	logic                            ld_out;

	// Effective window: zero counts as one, saturate at the row length.
	assign win_len_s = SW'(win_len_q);
	assign win_s = (win_len_q == '0) ? SW'(1) :
		((win_len_s > DEPTH_S) ? DEPTH_S : win_len_s);
	assign win = win_s[CW-1:0];

	assign vote.ready  = (state_q == ST_IDLE);
	assign accept      = vote.valid && vote.ready;
	assign accept_vote = accept && (vote.func != vwcd_pkg::FUNC_FORGET);
	assign fill_next   = (fill_q < win) ? (fill_q + CW'(1)) : fill_q;

	always_comb begin
		cell_ctrl.we   = accept_vote;
		cell_ctrl.clr  = accept && (vote.func == vwcd_pkg::FUNC_FORGET);
		cell_ctrl.vote = (vote.prob >= prob_min_q) ? vote.class_in : vwcd_pkg::CMD_UNCERTAIN;
	end

	assign close_c[0] = '0;
	assign open_c[0]  = '0;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		vwcd_cell #(
			.CNT_W(CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.sel      (wi_q[IW-1:0] == IW'(i)),
			.en       (CW'(i) < win),
			.close_in (close_c[i]),
			.open_in  (open_c[i]),
			.close_out(close_c[i+1]),
			.open_out (open_c[i+1])
		);
	end

	assign closes_m   = MW'(close_c[HISTORY_DEPTH]);
	assign opens_m    = MW'(open_c[HISTORY_DEPTH]);
	assign vmin_m     = MW'(vmin_q);
	assign tgt_close  = (closes_m >= vmin_m) && (closes_m > opens_m);
	assign tgt_open   = (opens_m >= vmin_m) && (opens_m > closes_m);
	assign dec_target = tgt_close ? vwcd_pkg::CMD_CLOSE :
		(tgt_open ? vwcd_pkg::CMD_OPEN : vwcd_pkg::CMD_UNCERTAIN);
	assign elapsed    = now_q - last_q;
	assign refr_block = has_sw_q && (elapsed < vwcd_pkg::TIME_W'(refr_q));
	assign dec_sw     = is_vote_q && full_q && (tgt_close || tgt_open) &&
		(dec_target != cmd_q) && !refr_block;
	assign ld_out     = (state_q == ST_RESULT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_len_q   <= vwcd_pkg::WIN_RST;
			vmin_q      <= vwcd_pkg::VMIN_RST;
			prob_min_q  <= vwcd_pkg::PROB_RST;
			refr_q      <= vwcd_pkg::REFR_RST;
			cmd_q       <= vwcd_pkg::CMD_RST;
			has_sw_q    <= 1'b0;
			last_q      <= '0;
			sw_total_q  <= '0;
			wi_q        <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			full_q      <= 1'b0;
			is_vote_q   <= 1'b0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			sw_out_q    <= 1'b0;
			cmd_out_q   <= '0;
			cnt_out_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (vwcd_pkg::reg_idx_t'(cfg_idx))
					vwcd_pkg::REG_WINDOW_LENGTH: begin
						win_len_q <= cfg_data[vwcd_pkg::WIN_W-1:0];
					end
					vwcd_pkg::REG_VOTES_MIN: begin
						vmin_q <= cfg_data[vwcd_pkg::VMIN_W-1:0];
					end
					vwcd_pkg::REG_PROB_MIN: begin
						prob_min_q <= cfg_data[vwcd_pkg::PROB_W-1:0];
					end
					vwcd_pkg::REG_REFRACTORY_MS: begin
						refr_q <= cfg_data[vwcd_pkg::REFR_W-1:0];
					end
					vwcd_pkg::REG_INITIAL_COMMAND: begin
						cmd_q <= cfg_data[vwcd_pkg::CMD_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept_vote) begin
						wi_q      <= wi_q + CW'(1);
						fill_q    <= fill_next;
						full_q    <= (fill_next >= win);
						now_q     <= vote.now_ms;
						is_vote_q <= 1'b1;
						cnt_q     <= '0;
						state_q   <= ST_COUNT;
					end else if (accept) begin
						wi_q      <= '0;
						fill_q    <= '0;
						is_vote_q <= 1'b0;
						state_q   <= ST_RESULT;
					end
				end
				ST_COUNT: begin
					// wrap the write index by repeated subtraction
					if (wi_q >= win) begin
						wi_q <= wi_q - win;
					end
					if (cnt_q == DEPTH_C) begin
						state_q <= ST_RESULT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_RESULT: begin
					if (ld_out) begin
						sw_out_q <= dec_sw;
						if (dec_sw) begin
							cmd_q      <= dec_target;
							has_sw_q   <= 1'b1;
							last_q     <= now_q;
							sw_total_q <= sw_total_q + vwcd_pkg::SWCNT_W'(1);
							cmd_out_q  <= dec_target;
							cnt_out_q  <= sw_total_q + vwcd_pkg::SWCNT_W'(1);
						end else begin
							cmd_out_q  <= cmd_q;
							cnt_out_q  <= sw_total_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.switched     = sw_out_q;
	assign result.command      = cmd_out_q;
	assign result.switch_count = cnt_out_q;

	`VWCD_ASSERT_NOW(a_switch_changes_cmd, ld_out && dec_sw, dec_target != cmd_q, "switch to same command")
	`VWCD_ASSERT_NEXT(a_switch_counts, ld_out && dec_sw, sw_total_q == $past(sw_total_q) + 16'd1, "switch count did not advance")
	`VWCD_ASSERT_NOW(a_index_wrapped, state_q == ST_RESULT, wi_q < win, "write index not wrapped by window")

endmodule
